/* rtl/core/cwl_pkg.sv */
// Shared types and constants for the comment, number and word lexer.
package cwl_pkg;

    localparam int CHAR_W = 16;
    localparam int LEN_W  = 16;
    localparam int VAL_W  = 32;
    localparam int KIND_W = 2;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_NUMBER     = 3'd2,
        MODE_WORD       = 3'd3,
        MODE_LINE       = 3'd4,
        MODE_BLOCK      = 3'd5,
        MODE_BLOCK_STAR = 3'd6
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_LINE   = 2'd2,
        KIND_BLOCK  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } char_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [LEN_W-1:0]  token_length;
        logic [VAL_W-1:0]  number_value;
    } token_item_t;

    typedef struct packed {
        logic       valid;
        char_item_t item;
    } step_t;

    typedef struct packed {
        logic        valid;
        token_item_t token;
    } result_t;

endpackage

/* rtl/core/cwl_if.sv */
// Valid/ready channel interfaces for characters and tokens.
interface cwl_char_if;
    logic                valid;
    logic                ready;
    cwl_pkg::char_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cwl_token_if;
    logic                 valid;
    logic                 ready;
    cwl_pkg::token_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/cwl_input_stage.sv */
// Input register for one character item.
module cwl_input_stage (
    input  logic            clk,
    input  logic            rst_n,
    cwl_char_if.sink        chars,
    input  logic            space,
    output cwl_pkg::step_t  step
);

    logic                valid_reg;
    logic                valid_next;
    cwl_pkg::char_item_t data_reg;
    logic                advance;
    logic                take;

    assign advance     = valid_reg && space;
    assign chars.ready = !valid_reg || advance;
    assign take        = chars.valid && chars.ready;
    assign valid_next  = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= chars.data;
        end
    end

    assign step.valid = advance;
    assign step.item  = data_reg;

endmodule

/* rtl/core/cwl_lexer_core.sv */
// Lexer state and per-character token logic.
module cwl_lexer_core #(
    parameter int CHAR_BITS   = 16,
    parameter int LENGTH_BITS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cwl_pkg::step_t   step,
    output cwl_pkg::result_t result
);

    localparam int PROD_W = VALUE_BITS + 4;

    cwl_pkg::mode_t           mode_reg;
    cwl_pkg::mode_t           mode_next;
    logic [LENGTH_BITS-1:0]   length_reg;
    logic [LENGTH_BITS-1:0]   length_next;
    logic [VALUE_BITS-1:0]    accum_reg;
    logic [VALUE_BITS-1:0]    accum_next;

    logic [CHAR_BITS-1:0]     c;
    logic                     last;
    logic                     is_term;
    logic                     is_digit;
    logic                     is_letter;
    logic                     is_slash;
    logic                     is_star;
    logic [3:0]               digit_val;

    cwl_pkg::mode_t           m;
    logic [LENGTH_BITS-1:0]   l;
    logic [VALUE_BITS-1:0]    a;
    logic                     emit;
    logic                     done;
    cwl_pkg::kind_t           kind;

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        if (v == {LENGTH_BITS{1'b1}})
        begin
            return v;
        end
        return v + LENGTH_BITS'(1);
    endfunction

    function automatic logic [VALUE_BITS-1:0] acc_digit(input logic [VALUE_BITS-1:0] v,
                                                         input logic [3:0] d);
        logic [PROD_W-1:0] p;
        p = (PROD_W'(v) << 3) + (PROD_W'(v) << 1) + PROD_W'(d);
        if (p[PROD_W-1:VALUE_BITS] != '0)
        begin
            return {VALUE_BITS{1'b1}};
        end
        return p[VALUE_BITS-1:0];
    endfunction

    always_comb
    begin
        c         = CHAR_BITS'(step.item.char_code);
        last      = step.item.last_char;
        is_term   = (c == CHAR_BITS'(cwl_pkg::CH_SPACE)) || (c == CHAR_BITS'(cwl_pkg::CH_NEWLINE));
        is_digit  = (c >= CHAR_BITS'(cwl_pkg::CH_ZERO)) && (c <= CHAR_BITS'(cwl_pkg::CH_NINE));
        is_letter = ((c >= CHAR_BITS'(cwl_pkg::CH_LOWER_A)) &&
                     (c <= CHAR_BITS'(cwl_pkg::CH_LOWER_Z))) ||
                    ((c >= CHAR_BITS'(cwl_pkg::CH_UPPER_A)) &&
                     (c <= CHAR_BITS'(cwl_pkg::CH_UPPER_Z)));
        is_slash  = (c == CHAR_BITS'(cwl_pkg::CH_SLASH));
        is_star   = (c == CHAR_BITS'(cwl_pkg::CH_STAR));
        digit_val = 4'(c - CHAR_BITS'(cwl_pkg::CH_ZERO));

        m    = mode_reg;
        l    = length_reg;
        a    = accum_reg;
        emit = 1'b0;
        done = 1'b0;
        kind = cwl_pkg::KIND_NUMBER;

        if (m == cwl_pkg::MODE_SLASH)
        begin
            if (is_slash)
            begin
                m    = cwl_pkg::MODE_LINE;
                l    = LENGTH_BITS'(2);
                emit = last;
                kind = cwl_pkg::KIND_LINE;
                done = 1'b1;
            end
            else if (is_star)
            begin
                m    = cwl_pkg::MODE_BLOCK;
                l    = '0;
                emit = last;
                kind = cwl_pkg::KIND_BLOCK;
                done = 1'b1;
            end
            else
            begin
                m = cwl_pkg::MODE_IDLE;
            end
        end

        if (!done)
        begin
            unique case (m) inside
                cwl_pkg::MODE_NUMBER, cwl_pkg::MODE_WORD:
                begin
                    kind = (m == cwl_pkg::MODE_NUMBER) ? cwl_pkg::KIND_NUMBER
                                                       : cwl_pkg::KIND_WORD;
                    if (is_term)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        l = sat_inc(l);
                        if (m == cwl_pkg::MODE_NUMBER)
                        begin
                            a = acc_digit(a, is_digit ? digit_val : 4'd0);
                        end
                        emit = last;
                    end
                end
                cwl_pkg::MODE_LINE:
                begin
                    kind = cwl_pkg::KIND_LINE;
                    if (c == CHAR_BITS'(cwl_pkg::CH_NEWLINE))
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        l    = sat_inc(l);
                        emit = last;
                    end
                end
                cwl_pkg::MODE_BLOCK:
                begin
                    kind = cwl_pkg::KIND_BLOCK;
                    if (is_star)
                    begin
                        m = cwl_pkg::MODE_BLOCK_STAR;
                    end
                    else
                    begin
                        l = sat_inc(l);
                    end
                    if (last)
                    begin
                        if (m == cwl_pkg::MODE_BLOCK_STAR)
                        begin
                            l = sat_inc(l);
                        end
                        emit = 1'b1;
                    end
                end
                cwl_pkg::MODE_BLOCK_STAR:
                begin
                    kind = cwl_pkg::KIND_BLOCK;
                    if (is_slash)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        l = sat_inc(l);
                        if (!is_star)
                        begin
                            l = sat_inc(l);
                            m = cwl_pkg::MODE_BLOCK;
                        end
                        if (last)
                        begin
                            if (m == cwl_pkg::MODE_BLOCK_STAR)
                            begin
                                l = sat_inc(l);
                            end
                            emit = 1'b1;
                        end
                    end
                end
                default:
                begin
                    m = cwl_pkg::MODE_IDLE;
                    if (is_slash)
                    begin
                        if (!last)
                        begin
                            m = cwl_pkg::MODE_SLASH;
                        end
                    end
                    else if (is_digit)
                    begin
                        m    = cwl_pkg::MODE_NUMBER;
                        l    = LENGTH_BITS'(1);
                        a    = VALUE_BITS'(digit_val);
                        emit = last;
                        kind = cwl_pkg::KIND_NUMBER;
                    end
                    else if (is_letter)
                    begin
                        m    = cwl_pkg::MODE_WORD;
                        l    = LENGTH_BITS'(1);
                        a    = '0;
                        emit = last;
                        kind = cwl_pkg::KIND_WORD;
                    end
                end
            endcase
        end

        if (emit)
        begin
            mode_next   = cwl_pkg::MODE_IDLE;
            length_next = '0;
            accum_next  = '0;
        end
        else
        begin
            mode_next   = m;
            length_next = l;
            accum_next  = a;
        end

        result.valid              = step.valid && emit;
        result.token.token_kind   = kind;
        result.token.token_length = cwl_pkg::LEN_W'(l);
        result.token.number_value = (kind == cwl_pkg::KIND_NUMBER) ? cwl_pkg::VAL_W'(a) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= cwl_pkg::MODE_IDLE;
            length_reg <= '0;
            accum_reg  <= '0;
        end
        else if (step.valid)
        begin
            mode_reg   <= mode_next;
            length_reg <= length_next;
            accum_reg  <= accum_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |=> (mode_reg == cwl_pkg::MODE_IDLE && length_reg == '0 && accum_reg == '0))
        else $error("lexer state not cleared after token");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step.valid && step.item.last_char) |=> (mode_reg == cwl_pkg::MODE_IDLE))
        else $error("lexer not idle after final character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != cwl_pkg::MODE_NUMBER) |-> (accum_reg == '0))
        else $error("value accumulated outside a number");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == cwl_pkg::MODE_IDLE || mode_reg == cwl_pkg::MODE_SLASH) |->
        (length_reg == '0))
        else $error("length held while no token is open");

endmodule

/* rtl/core/cwl_output_stage.sv */
// Result register for one token item.
module cwl_output_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  cwl_pkg::result_t result,
    output logic             space,
    cwl_token_if.source      tokens
);

    logic                 valid_reg;
    logic                 valid_next;
    cwl_pkg::token_item_t data_reg;

    assign space      = !valid_reg || tokens.ready;
    assign valid_next = result.valid || (valid_reg && !tokens.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            data_reg <= result.token;
        end
    end

    assign tokens.valid = valid_reg;
    assign tokens.data  = data_reg;

endmodule

/* rtl/core/comment_number_word_lexer.sv */
// Top level of the streaming comment, number and word lexer.
//
// chars carries one character item per handshake (char_code, last_char);
// tokens carries one token item (token_kind, token_length, number_value).
// An item is taken when valid and ready are both high at a rising edge.
// A character goes into the input register, is lexed from there by the
// mode update and a shift-add multiply by ten once the result register
// has space, and any token it closes lands in the result register. One
// character is taken every cycle unless tokens stalls with a token held;
// the mode and accumulator update is combinational.
// Most characters give no token; at most one token per character.
// When tokens is stalled, the held token stays in the result register
// and one more character can wait in the input register; chars.ready
// drops only when both are full.
// rst_n (asynchronous, active low) empties both registers and returns
// the lexer to idle with zero length and value.
module comment_number_word_lexer #(
    parameter int CHAR_BITS   = 16,
    parameter int LENGTH_BITS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    cwl_char_if.sink    chars,
    cwl_token_if.source tokens
);

    cwl_pkg::step_t   step;
    cwl_pkg::result_t result;
    logic             space;

    cwl_input_stage u_input (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .space (space),
        .step  (step)
    );

    cwl_lexer_core #(
        .CHAR_BITS   (CHAR_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    cwl_output_stage u_output (
        .clk    (clk),
        .rst_n  (rst_n),
        .result (result),
        .space  (space),
        .tokens (tokens)
    );

endmodule

/* test/comment_number_word_lexer_tb.sv */
// Self-checking testbench for the comment, number and word lexer.
module comment_number_word_lexer_tb;

    logic clk;
    logic rst_n;

    cwl_char_if  char_ch ();
    cwl_token_if tok_ch ();

    comment_number_word_lexer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_ch),
        .tokens (tok_ch)
    );

    cwl_pkg::mode_t             lex_mode  = cwl_pkg::MODE_IDLE;
    logic [cwl_pkg::LEN_W-1:0]  tok_len   = '0;
    logic [cwl_pkg::VAL_W-1:0]  value_acc = '0;

    cwl_pkg::token_item_t pending_tokens[$];
    cwl_pkg::token_item_t lexed_tok;
    cwl_pkg::token_item_t want_tok;
    bit                   lexed_one;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned hold_off_left = 0;
    int unsigned hold_off_req  = 0;
    int unsigned hold_off_ack  = 0;
    int          chars_sent    = 0;
    int          tokens_checked = 0;
    int          mismatches    = 0;
    int          kind_seen[4]  = '{0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void bump_length();
        if (tok_len != '1)
            tok_len = tok_len + cwl_pkg::LEN_W'(1);
    endfunction

    function automatic void push_digit(input logic [3:0] d);
        logic [cwl_pkg::VAL_W+3:0] wide;
        wide = {4'b0, value_acc} * (cwl_pkg::VAL_W + 4)'(10) + (cwl_pkg::VAL_W + 4)'(d);
        value_acc = (wide > (cwl_pkg::VAL_W + 4)'({cwl_pkg::VAL_W{1'b1}})) ? '1
                                                                           : wide[cwl_pkg::VAL_W-1:0];
    endfunction

    function automatic void close_token(input cwl_pkg::kind_t kind,
                                        output cwl_pkg::token_item_t tok);
        tok.token_kind   = kind;
        tok.token_length = tok_len;
        tok.number_value = (kind == cwl_pkg::KIND_NUMBER) ? value_acc : '0;
        lex_mode  = cwl_pkg::MODE_IDLE;
        tok_len   = '0;
        value_acc = '0;
    endfunction

    // Advance the lexer by one character; returns 1 when a token closes.
    function automatic bit lex_char(input logic [cwl_pkg::CHAR_W-1:0] c, input logic last,
                                    output cwl_pkg::token_item_t tok);
        bit             term;
        bit             digit;
        bit             letter;
        cwl_pkg::kind_t run_kind;
        term   = (c == cwl_pkg::CH_SPACE) || (c == cwl_pkg::CH_NEWLINE);
        digit  = (c >= cwl_pkg::CH_ZERO) && (c <= cwl_pkg::CH_NINE);
        letter = ((c >= cwl_pkg::CH_LOWER_A) && (c <= cwl_pkg::CH_LOWER_Z)) ||
                 ((c >= cwl_pkg::CH_UPPER_A) && (c <= cwl_pkg::CH_UPPER_Z));
        tok = '0;
        if (lex_mode == cwl_pkg::MODE_SLASH)
        begin
            if (c == cwl_pkg::CH_SLASH)
            begin
                lex_mode = cwl_pkg::MODE_LINE;
                tok_len  = cwl_pkg::LEN_W'(2);
                if (last)
                    close_token(cwl_pkg::KIND_LINE, tok);
                return last;
            end
            if (c == cwl_pkg::CH_STAR)
            begin
                lex_mode = cwl_pkg::MODE_BLOCK;
                tok_len  = '0;
                if (last)
                    close_token(cwl_pkg::KIND_BLOCK, tok);
                return last;
            end
            lex_mode = cwl_pkg::MODE_IDLE;
        end
        case (lex_mode)
            cwl_pkg::MODE_IDLE:
            begin
                if (c == cwl_pkg::CH_SLASH)
                begin
                    if (!last)
                        lex_mode = cwl_pkg::MODE_SLASH;
                    return 1'b0;
                end
                if (digit || letter)
                begin
                    lex_mode  = digit ? cwl_pkg::MODE_NUMBER : cwl_pkg::MODE_WORD;
                    tok_len   = cwl_pkg::LEN_W'(1);
                    value_acc = '0;
                    if (digit)
                        push_digit(c[3:0]);
                    if (last)
                        close_token(digit ? cwl_pkg::KIND_NUMBER : cwl_pkg::KIND_WORD, tok);
                    return last;
                end
                return 1'b0;
            end
            cwl_pkg::MODE_NUMBER, cwl_pkg::MODE_WORD:
            begin
                run_kind = (lex_mode == cwl_pkg::MODE_NUMBER) ? cwl_pkg::KIND_NUMBER
                                                              : cwl_pkg::KIND_WORD;
                if (term)
                begin
                    close_token(run_kind, tok);
                    return 1'b1;
                end
                bump_length();
                if (run_kind == cwl_pkg::KIND_NUMBER)
                    push_digit(digit ? c[3:0] : 4'd0);
                if (last)
                    close_token(run_kind, tok);
                return last;
            end
            cwl_pkg::MODE_LINE:
            begin
                if (c == cwl_pkg::CH_NEWLINE)
                begin
                    close_token(cwl_pkg::KIND_LINE, tok);
                    return 1'b1;
                end
                bump_length();
                if (last)
                    close_token(cwl_pkg::KIND_LINE, tok);
                return last;
            end
            cwl_pkg::MODE_BLOCK:
            begin
                if (c == cwl_pkg::CH_STAR)
                    lex_mode = cwl_pkg::MODE_BLOCK_STAR;
                else
                    bump_length();
            end
            cwl_pkg::MODE_BLOCK_STAR:
            begin
                if (c == cwl_pkg::CH_SLASH)
                begin
                    close_token(cwl_pkg::KIND_BLOCK, tok);
                    return 1'b1;
                end
                bump_length();
                if (c != cwl_pkg::CH_STAR)
                begin
                    bump_length();
                    lex_mode = cwl_pkg::MODE_BLOCK;
                end
            end
            default:
                return 1'b0;
        endcase
        if (last)
        begin
            if (lex_mode == cwl_pkg::MODE_BLOCK_STAR)
                bump_length();
            close_token(cwl_pkg::KIND_BLOCK, tok);
        end
        return last;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                lexed_one = lex_char(char_ch.data.char_code, char_ch.data.last_char,
                                     lexed_tok);
                if (lexed_one)
                    pending_tokens = {pending_tokens, lexed_tok};
            end
            if (tok_ch.valid && tok_ch.ready)
            begin
                tokens_checked++;
                kind_seen[tok_ch.data.token_kind]++;
                if (pending_tokens.size() == 0)
                    report_mismatch("unexpected token, length",
                                    32'(tok_ch.data.token_length), 32'd0);
                else
                begin
                    want_tok = pending_tokens.pop_front();
                    if (tok_ch.data.token_kind !== want_tok.token_kind)
                        report_mismatch("token_kind", 32'(tok_ch.data.token_kind),
                                        32'(want_tok.token_kind));
                    if (tok_ch.data.token_length !== want_tok.token_length)
                        report_mismatch("token_length", 32'(tok_ch.data.token_length),
                                        32'(want_tok.token_length));
                    if (tok_ch.data.number_value !== want_tok.number_value)
                        report_mismatch("number_value", tok_ch.data.number_value,
                                        want_tok.number_value);
                end
            end
        end
    end

    initial
    begin
        tok_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_ack != hold_off_req)
            begin
                hold_off_ack  = hold_off_req;
                hold_off_left = 150;
            end
            if (hold_off_left > 0)
            begin
                tok_ch.ready  <= 1'b0;
                hold_off_left = hold_off_left - 1;
            end
            else
                tok_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_char(input logic [cwl_pkg::CHAR_W-1:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_ch.valid <= 1'b0;
            @(negedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.data  <= '{char_code: c, last_char: last};
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(cwl_pkg::CHAR_W'(s[i]), last_at_end && (i == s.len() - 1));
    endtask

    task automatic wait_for_tokens();
        char_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_tokens.size() != 0);
    endtask

    function automatic logic [cwl_pkg::CHAR_W-1:0] rand_letter();
        if ($urandom_range(1))
            return cwl_pkg::CHAR_W'(cwl_pkg::CH_LOWER_A) + cwl_pkg::CHAR_W'($urandom_range(25));
        return cwl_pkg::CHAR_W'(cwl_pkg::CH_UPPER_A) + cwl_pkg::CHAR_W'($urandom_range(25));
    endfunction

    function automatic logic [cwl_pkg::CHAR_W-1:0] rand_text_char();
        case ($urandom_range(7))
            0:       return rand_letter();
            1:       return cwl_pkg::CHAR_W'(cwl_pkg::CH_ZERO) +
                            cwl_pkg::CHAR_W'($urandom_range(9));
            2:       return cwl_pkg::CHAR_W'(cwl_pkg::CH_SPACE);
            3:       return cwl_pkg::CHAR_W'(cwl_pkg::CH_NEWLINE);
            4:       return cwl_pkg::CHAR_W'(cwl_pkg::CH_STAR);
            5:       return cwl_pkg::CHAR_W'(cwl_pkg::CH_SLASH);
            6:       return cwl_pkg::CHAR_W'($urandom_range(127));
            default: return cwl_pkg::CHAR_W'($urandom);
        endcase
    endfunction

    // A body character occasionally carries the final-character mark.
    task automatic send_body(input logic [cwl_pkg::CHAR_W-1:0] c);
        send_char(c, $urandom_range(49) == 0);
    endtask

    task automatic send_ending();
        case ($urandom_range(9))
            0:       send_char(cwl_pkg::CHAR_W'(cwl_pkg::CH_SPACE), 1'b1);
            1, 2, 3: send_char(cwl_pkg::CHAR_W'(cwl_pkg::CH_NEWLINE), 1'b0);
            default: send_char(cwl_pkg::CHAR_W'(cwl_pkg::CH_SPACE), 1'b0);
        endcase
    endtask

    task automatic send_random_phrase();
        int n;
        n = $urandom_range(1, 12);
        case ($urandom_range(9))
            0, 1:
            begin
                for (int i = 0; i < n; i++)
                    if ($urandom_range(15) == 0)
                        send_body(rand_text_char());
                    else
                        send_body(cwl_pkg::CHAR_W'(cwl_pkg::CH_ZERO) +
                                  cwl_pkg::CHAR_W'($urandom_range(9)));
                send_ending();
            end
            2, 3:
            begin
                send_body(rand_letter());
                for (int i = 1; i < (n % 9) + 1; i++)
                    send_body($urandom_range(5) ? rand_letter() : rand_text_char());
                send_ending();
            end
            4:
            begin
                send_text("//", $urandom_range(19) == 0);
                for (int i = 0; i < n - 1; i++)
                    send_body(rand_text_char());
                send_char(cwl_pkg::CHAR_W'(cwl_pkg::CH_NEWLINE), 1'b0);
            end
            5:
            begin
                send_text("/*", $urandom_range(19) == 0);
                for (int i = 0; i < n - 1; i++)
                    case ($urandom_range(3))
                        0:       send_body(cwl_pkg::CHAR_W'(cwl_pkg::CH_STAR));
                        1:       send_body(cwl_pkg::CHAR_W'(cwl_pkg::CH_SLASH));
                        default: send_body(rand_text_char());
                    endcase
                send_text("*/", $urandom_range(9) == 0);
            end
            6:
                send_char($urandom_range(1) ? cwl_pkg::CHAR_W'(cwl_pkg::CH_SPACE)
                                            : cwl_pkg::CHAR_W'(cwl_pkg::CH_NEWLINE),
                          $urandom_range(9) == 0);
            7:
                send_char(cwl_pkg::CHAR_W'($urandom), $urandom_range(3) == 0);
            default:
            begin
                send_char(cwl_pkg::CHAR_W'(cwl_pkg::CH_SLASH), $urandom_range(9) == 0);
                send_body(rand_text_char());
            end
        endcase
    endtask

    task automatic test_token_kinds();
        send_text("Az 9x0\n//Z\n/**a*/", 1'b0);
        send_text("z", 1'b1);
    endtask

    task automatic test_flush_cases();
        send_text("//", 1'b1);
        send_text("/*", 1'b1);
        send_text("/*b*", 1'b1);
        send_text("/", 1'b1);
        send_text("/q\n", 1'b0);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0000, 1'b0);
        send_char(16'h0139, 1'b0);
        send_text("7", 1'b1);
        wait_for_tokens();
    endtask

    task automatic test_value_saturation();
        send_text("4294967295 ", 1'b0);
        send_text("99999999999", 1'b1);
        wait_for_tokens();
    endtask

    task automatic test_backpressure();
        hold_off_req = hold_off_req + 1;
        for (int i = 0; i < 12; i++)
        begin
            send_text("12 ", 1'b0);
            send_char(rand_letter(), 1'b0);
            send_char(cwl_pkg::CHAR_W'(cwl_pkg::CH_NEWLINE), 1'b0);
        end
        wait_for_tokens();
    endtask

    task automatic test_random_traffic(input int count);
        int goal;
        goal = chars_sent + count;
        while (chars_sent < goal)
            send_random_phrase();
        wait_for_tokens();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        char_ch.valid = 1'b0;
        char_ch.data  = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 69;
        test_token_kinds();
        test_flush_cases();
        test_value_saturation();
        test_backpressure();
        test_random_traffic(450);

        send_idle_pct = 69;
        recv_idle_pct = 20;
        test_random_traffic(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(380);

        wait_for_tokens();
        repeat (10) @(negedge clk);

        $display("Sent %0d characters; checked %0d tokens", chars_sent, tokens_checked);
        $display("Kinds: number %0d, word %0d, line %0d, block %0d; %0d mismatches",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], mismatches);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/cwl_pkg.sv
rtl/core/cwl_if.sv
rtl/core/cwl_input_stage.sv
rtl/core/cwl_lexer_core.sv
rtl/core/cwl_output_stage.sv
rtl/core/comment_number_word_lexer.sv
test/comment_number_word_lexer_tb.sv
